// ===== hdl/triple_frame_buffer_owner_defines.svh =====
// ----------------------------------------------------------------------------
// Triple frame buffer owner assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef TRIPLE_FRAME_BUFFER_OWNER_DEFINES_SVH
`define TRIPLE_FRAME_BUFFER_OWNER_DEFINES_SVH

// Checked only while the block is out of reset.
`define TFBO_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TFBO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/tfbo_pkg.sv =====
// ----------------------------------------------------------------------------
// Triple frame buffer owner package
// Shared types, codes and constants for the buffer ownership block.
// ----------------------------------------------------------------------------
`default_nettype none

package tfbo_pkg;

	localparam int NUM_BUFFERS_DEF  = 3;
	localparam int BYTES_W          = 24;
	localparam int COUNT_W          = 32;
	localparam logic [BYTES_W-1:0] FRAME_BYTES_RST = 24'd1280000;
	localparam logic [1:0] NO_BUFFER = 2'd3;

	typedef enum logic [1:0] {
		FN_DMA_REQ = 2'd0,
		FN_FRAME_DONE = 2'd1,
		FN_ACQUIRE = 2'd2,
		FN_RELEASE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		OWN_FREE = 2'd0,
		OWN_DMA = 2'd1,
		OWN_READY = 2'd2,
		OWN_READING = 2'd3
	} own_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

`default_nettype wire

// ===== hdl/tfbo_ctrl.sv =====
// ----------------------------------------------------------------------------
// Triple frame buffer owner controller
// Sequences capture and execution of one transaction and owns output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module tfbo_ctrl import tfbo_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output cmd_t      cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	// The output register can take a new result when empty or being drained.
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/tfbo_datapath.sv =====
// ----------------------------------------------------------------------------
// Triple frame buffer owner datapath
// Ownership table, frame counters, size register and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tfbo_datapath import tfbo_pkg::*; #(
	parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	input  wire logic [1:0]         func,
	input  wire logic [1:0]         buf_index,
	input  wire logic [BYTES_W-1:0] received_bytes,
	input  wire logic               cfg_we,
	input  wire logic [BYTES_W-1:0] cfg_wdata,
	output logic                    granted,
	output logic [1:0]              buffer_index,
	output logic [BYTES_W-1:0]      buffer_length,
	output logic [COUNT_W-1:0]      frame_total,
	output logic [COUNT_W-1:0]      bad_size_total,
	output logic [BYTES_W-1:0]      last_frame_bytes
);

	localparam int IDX_W = $clog2(NUM_BUFFERS);

	// Captured transaction
	func_t              func_s1;
	logic [1:0]         buf_index_s1;
	logic [BYTES_W-1:0] bytes_s1;

	// Architectural state
	own_t               owner_q [NUM_BUFFERS];
	own_t               owner_d [NUM_BUFFERS];
	logic [COUNT_W-1:0] frame_cnt_q, frame_cnt_d;
	logic [COUNT_W-1:0] bad_cnt_q, bad_cnt_d;
	logic [BYTES_W-1:0] last_size_q, last_size_d;
	logic [BYTES_W-1:0] frame_bytes_q;

	// Result register
	logic               granted_q;
	logic [1:0]         buffer_index_q;
	logic [BYTES_W-1:0] buffer_length_q;

	logic [NUM_BUFFERS-1:0] hit;
	logic                   free_found, ready_found, hit_dma, size_ok;
	logic [IDX_W-1:0]       free_idx, ready_idx, pick_idx;
	logic                   pick_valid;
	own_t                   pick_state;
	logic [IDX_W+1:0]       pick_ext;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_s1      <= func_t'(func);
			buf_index_s1 <= buf_index;
			bytes_s1     <= received_bytes;
		end
	end

	// Lowest free and lowest ready buffers, searched in parallel.
	always_comb begin
		free_found  = 1'b0;
		ready_found = 1'b0;
		free_idx    = '0;
		ready_idx   = '0;
		hit_dma     = 1'b0;
		for (int j = NUM_BUFFERS - 1; j >= 0; j--) begin
			hit[j] = ((IDX_W+2)'(buf_index_s1) == (IDX_W+2)'(j));
			if (owner_q[j] == OWN_FREE) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(j);
			end
			if (owner_q[j] == OWN_READY) begin
				ready_found = 1'b1;
				ready_idx   = IDX_W'(j);
			end
			if (hit[j] && owner_q[j] == OWN_DMA) hit_dma = 1'b1;
		end
	end

	assign size_ok = (bytes_s1 == frame_bytes_q);

	always_comb begin
		pick_valid  = 1'b0;
		pick_idx    = '0;
		pick_state  = OWN_DMA;
		frame_cnt_d = frame_cnt_q;
		bad_cnt_d   = bad_cnt_q;
		last_size_d = last_size_q;
		for (int j = 0; j < NUM_BUFFERS; j++) owner_d[j] = owner_q[j];

		unique case (func_s1)
			FN_DMA_REQ: begin
				// Falling back to a ready buffer drops its older frame.
				pick_state = OWN_DMA;
				if (free_found) begin
					pick_valid = 1'b1;
					pick_idx   = free_idx;
				end else if (ready_found) begin
					pick_valid = 1'b1;
					pick_idx   = ready_idx;
				end
			end
			FN_FRAME_DONE: begin
				frame_cnt_d = frame_cnt_q + 1'b1;
				last_size_d = bytes_s1;
				if (!size_ok) bad_cnt_d = bad_cnt_q + 1'b1;
				for (int j = 0; j < NUM_BUFFERS; j++) begin
					if (hit_dma && size_ok && owner_q[j] == OWN_READY)
						owner_d[j] = OWN_FREE;
					if (hit[j] && owner_q[j] == OWN_DMA)
						owner_d[j] = size_ok ? OWN_READY : OWN_FREE;
				end
			end
			FN_ACQUIRE: begin
				pick_state = OWN_READING;
				pick_valid = ready_found;
				pick_idx   = ready_idx;
			end
			FN_RELEASE: begin
				for (int j = 0; j < NUM_BUFFERS; j++)
					if (hit[j] && owner_q[j] == OWN_READING) owner_d[j] = OWN_FREE;
			end
			default: ;
		endcase

		if (pick_valid) begin
			for (int j = 0; j < NUM_BUFFERS; j++)
				if (pick_idx == IDX_W'(j)) owner_d[j] = pick_state;
		end
	end

	assign pick_ext = {2'b00, pick_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_BUFFERS; j++) owner_q[j] <= OWN_FREE;
			frame_cnt_q   <= '0;
			bad_cnt_q     <= '0;
			last_size_q   <= '0;
			frame_bytes_q <= FRAME_BYTES_RST;
		end else begin
			if (cfg_we) frame_bytes_q <= cfg_wdata;
			if (cmd.exec) begin
				for (int j = 0; j < NUM_BUFFERS; j++) owner_q[j] <= owner_d[j];
				frame_cnt_q <= frame_cnt_d;
				bad_cnt_q   <= bad_cnt_d;
				last_size_q <= last_size_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			granted_q       <= pick_valid;
			buffer_index_q  <= pick_valid ? pick_ext[1:0] : NO_BUFFER;
			buffer_length_q <= pick_valid ? frame_bytes_q : '0;
		end
	end

	// The counter registers are only written alongside the result register,
	// so they always match the result being shown.
	assign granted          = granted_q;
	assign buffer_index     = buffer_index_q;
	assign buffer_length    = buffer_length_q;
	assign frame_total      = frame_cnt_q;
	assign bad_size_total   = bad_cnt_q;
	assign last_frame_bytes = last_size_q;

endmodule

`default_nettype wire

// ===== hdl/triple_frame_buffer_owner.sv =====
// Usage: frame buffer ownership tracker shared by a capture DMA and a reader.
// The input channel (in_valid/in_ready) carries one operation per transaction:
// func selects DMA request, frame done, reader acquire or reader release, with
// buf_index and received_bytes as operands. The output channel
// (out_valid/out_ready) returns exactly one result per operation, in order.
// An operation passes through the controller in order: the idle state
// captures it, then the execute state updates the ownership table and loads
// the result register, which raises out_valid; no new operation is taken
// until that step is done. A new operation is accepted while a previous
// result still waits in the result register; if the receiver stalls, the
// update waits until that register drains, and in_ready stays low meanwhile.
// Reset frees every buffer, clears the counters and last size, and loads the
// expected frame size register with its default. That register is written
// through cfg_we and cfg_wdata in a single cycle and should only change while
// the block is idle.
// ----------------------------------------------------------------------------
// Triple frame buffer owner
// Top level joining the sequencing controller and the ownership datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module triple_frame_buffer_owner import tfbo_pkg::*; #(
	parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         func,
	input  wire logic [1:0]         buf_index,
	input  wire logic [BYTES_W-1:0] received_bytes,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    granted,
	output logic [1:0]              buffer_index,
	output logic [BYTES_W-1:0]      buffer_length,
	output logic [COUNT_W-1:0]      frame_total,
	output logic [COUNT_W-1:0]      bad_size_total,
	output logic [BYTES_W-1:0]      last_frame_bytes,
	input  wire logic               cfg_we,
	input  wire logic [BYTES_W-1:0] cfg_wdata
);

	cmd_t cmd;

	tfbo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	tfbo_datapath #(
		.NUM_BUFFERS (NUM_BUFFERS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.func             (func),
		.buf_index        (buf_index),
		.received_bytes   (received_bytes),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.granted          (granted),
		.buffer_index     (buffer_index),
		.buffer_length    (buffer_length),
		.frame_total      (frame_total),
		.bad_size_total   (bad_size_total),
		.last_frame_bytes (last_frame_bytes)
	);

endmodule

`default_nettype wire

// ===== hdl/tfbo_checker.sv =====
// ----------------------------------------------------------------------------
// Triple frame buffer owner port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triple_frame_buffer_owner_defines.svh"

module tfbo_checker import tfbo_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic [1:0]         func,
	input wire logic [1:0]         buf_index,
	input wire logic [BYTES_W-1:0] received_bytes,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               granted,
	input wire logic [1:0]         buffer_index,
	input wire logic [BYTES_W-1:0] buffer_length,
	input wire logic [COUNT_W-1:0] frame_total,
	input wire logic [COUNT_W-1:0] bad_size_total,
	input wire logic [BYTES_W-1:0] last_frame_bytes,
	input wire logic               cfg_we,
	input wire logic [BYTES_W-1:0] cfg_wdata
);

	// No result can be pending while reset is held.
	`TFBO_ASSERT_ALWAYS(a_no_out_in_reset, clk, !arst_n |-> !out_valid, "out_valid during reset")

	// A stalled result keeps its counters.
	`TFBO_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(frame_total) && $stable(bad_size_total) && $stable(last_frame_bytes), "stalled result changed")

	// A result without a grant names no buffer and carries no length.
	`TFBO_ASSERT(a_no_grant_fields, clk, arst_n, out_valid && !granted |-> buffer_index == NO_BUFFER && buffer_length == '0, "ungranted result carries a buffer")

	// One operation at a time: the cycle after acceptance is busy.
	`TFBO_ASSERT(a_busy_after_accept, clk, arst_n, in_valid && in_ready |=> !in_ready, "input accepted twice in a row")

endmodule

bind triple_frame_buffer_owner tfbo_checker u_tfbo_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Triple frame buffer owner testbench
// Sends buffer ownership operations through the valid/ready input channel.
// A behavioural copy of the ownership table and the frame counters predicts
// every reply, and each reply is compared field by field in order. The run
// covers several expected frame sizes and several pacing phases, including
// a long receiver hold-off that makes the block stall its input.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tfbo_pkg::*;

	localparam int NB = NUM_BUFFERS_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 60;
	localparam int DRAIN_CYCLES = 6;
	localparam int PRINT_LIMIT = 100;

	typedef struct packed {
		own_t [NB-1:0]      owner;
		logic [COUNT_W-1:0] frames;
		logic [COUNT_W-1:0] bad_frames;
		logic [BYTES_W-1:0] last_len;
		logic [BYTES_W-1:0] exp_len;
	} buffer_table_t;

	typedef struct packed {
		func_t              fn;
		logic [1:0]         idx;
		logic [BYTES_W-1:0] bytes;
	} own_op_t;

	typedef struct packed {
		logic               granted;
		logic [1:0]         index;
		logic [BYTES_W-1:0] length;
		logic [COUNT_W-1:0] frames;
		logic [COUNT_W-1:0] bad_frames;
		logic [BYTES_W-1:0] last_len;
	} reply_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         func = 2'd0;
	logic [1:0]         buf_index = 2'd0;
	logic [BYTES_W-1:0] received_bytes = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               granted;
	logic [1:0]         buffer_index;
	logic [BYTES_W-1:0] buffer_length;
	logic [COUNT_W-1:0] frame_total;
	logic [COUNT_W-1:0] bad_size_total;
	logic [BYTES_W-1:0] last_frame_bytes;
	logic               cfg_we = 1'b0;
	logic [BYTES_W-1:0] cfg_wdata = '0;

	own_op_t       queued_ops[$];
	reply_t        owed_replies[$];
	buffer_table_t tracked_table;
	buffer_table_t planned_table;

	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_go = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;
	bit item_taken = 1'b0;
	int quiet_cycles = 0;
	int n_ops = 0;
	int n_replies = 0;
	int n_grants = 0;
	int n_settings = 1;
	int n_errors = 0;

	triple_frame_buffer_owner #(
		.NUM_BUFFERS(NB)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.buf_index(buf_index),
		.received_bytes(received_bytes),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.granted(granted),
		.buffer_index(buffer_index),
		.buffer_length(buffer_length),
		.frame_total(frame_total),
		.bad_size_total(bad_size_total),
		.last_frame_bytes(last_frame_bytes),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic buffer_table_t table_at_reset();
		buffer_table_t t;
		t = '0;
		for (int i = 0; i < NB; i++) begin
			t.owner[i] = OWN_FREE;
		end
		t.exp_len = FRAME_BYTES_RST;
		return t;
	endfunction

	function automatic int lowest_owned(input buffer_table_t t, input own_t code);
		for (int i = 0; i < NB; i++) begin
			if (t.owner[i] == code)
				return i;
		end
		return -1;
	endfunction

	// Any buffer in the given state, searched from a random start.
	function automatic int some_owned(input buffer_table_t t, input own_t code);
		int start;
		int slot;
		start = $urandom_range(NB - 1);
		for (int k = 0; k < NB; k++) begin
			slot = (start + k) % NB;
			if (t.owner[slot] == code)
				return slot;
		end
		return -1;
	endfunction

	function automatic void apply_ownership_op(inout buffer_table_t t, input own_op_t op,
			output reply_t r);
		int  pick;
		logic named;
		pick = -1;
		named = (op.idx < NB);
		case (op.fn)
			FN_DMA_REQ: begin
				pick = lowest_owned(t, OWN_FREE);
				if (pick < 0)
					pick = lowest_owned(t, OWN_READY);
				if (pick >= 0)
					t.owner[pick] = OWN_DMA;
			end
			FN_FRAME_DONE: begin
				t.frames = t.frames + 1'b1;
				t.last_len = op.bytes;
				if (op.bytes != t.exp_len)
					t.bad_frames = t.bad_frames + 1'b1;
				if (named && t.owner[op.idx] == OWN_DMA) begin
					if (op.bytes == t.exp_len) begin
						// Only the newest good frame stays ready.
						for (int j = 0; j < NB; j++) begin
							if (t.owner[j] == OWN_READY)
								t.owner[j] = OWN_FREE;
						end
						t.owner[op.idx] = OWN_READY;
					end else begin
						t.owner[op.idx] = OWN_FREE;
					end
				end
			end
			FN_ACQUIRE: begin
				pick = lowest_owned(t, OWN_READY);
				if (pick >= 0)
					t.owner[pick] = OWN_READING;
			end
			default: begin
				if (named && t.owner[op.idx] == OWN_READING)
					t.owner[op.idx] = OWN_FREE;
			end
		endcase
		r.granted = (pick >= 0);
		r.index = (pick >= 0) ? pick[1:0] : NO_BUFFER;
		r.length = (pick >= 0) ? t.exp_len : '0;
		r.frames = t.frames;
		r.bad_frames = t.bad_frames;
		r.last_len = t.last_len;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		n_errors++;
		if (n_errors <= PRINT_LIMIT)
			$display("mismatch on reply %0d: %s is %0h, predicted %0h", n_replies, what, got,
				want);
	endtask

	// Driver: a transaction stays on the port until the block accepts it.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || item_taken) begin
			if (queued_ops.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				in_valid <= 1'b1;
				func <= queued_ops[0].fn;
				buf_index <= queued_ops[0].idx;
				received_bytes <= queued_ops[0].bytes;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_go != hold_seen) begin
			hold_seen = hold_go;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: replies are checked before the new transaction is predicted, so a
	// reply that arrives with nothing owed is caught.
	always @(posedge clk) begin
		reply_t  want;
		reply_t  next;
		own_op_t seen;
		bit      took;
		bit      gave;
		took = 1'b0;
		gave = 1'b0;
		if (arst_n) begin
			if (cfg_we)
				tracked_table.exp_len = cfg_wdata;
			gave = out_valid && out_ready;
			took = in_valid && in_ready;
			if (gave) begin
				n_replies++;
				if (owed_replies.size() == 0) begin
					report_mismatch("reply with nothing owed, buffer_index", buffer_index, 0);
				end else begin
					want = owed_replies.pop_front();
					if (granted !== want.granted)
						report_mismatch("granted", granted, want.granted);
					if (buffer_index !== want.index)
						report_mismatch("buffer_index", buffer_index, want.index);
					if (buffer_length !== want.length)
						report_mismatch("buffer_length", buffer_length, want.length);
					if (frame_total !== want.frames)
						report_mismatch("frame_total", frame_total, want.frames);
					if (bad_size_total !== want.bad_frames)
						report_mismatch("bad_size_total", bad_size_total, want.bad_frames);
					if (last_frame_bytes !== want.last_len)
						report_mismatch("last_frame_bytes", last_frame_bytes, want.last_len);
					if (want.granted)
						n_grants++;
				end
			end
			if (took) begin
				seen = own_op_t'{func_t'(func), buf_index, received_bytes};
				apply_ownership_op(tracked_table, seen, next);
				owed_replies.push_back(next);
				void'(queued_ops.pop_front());
				n_ops++;
			end
			if (took || gave)
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
		end
		item_taken = took;
	end

	initial begin : watchdog
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
		$display("FAILURE");
		$finish;
	end

	task automatic queue_op(input own_op_t op);
		reply_t unused;
		apply_ownership_op(planned_table, op, unused);
		queued_ops.push_back(op);
	endtask

	task automatic wait_drained();
		while (queued_ops.size() != 0 || owed_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_expected_len(input logic [BYTES_W-1:0] value);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		planned_table.exp_len = value;
		n_settings++;
	endtask

	// Mostly well-formed capture and read sequences, with some noise mixed in.
	task automatic run_phase(input int count, input int idle_pct, input int stall_pct,
			input bit squeeze);
		own_op_t op;
		int      r;
		int      k;
		int      slot;
		@(posedge clk);
		sender_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		if (squeeze)
			hold_go = ~hold_go;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			op = '0;
			if (r < 25) begin
				op.fn = FN_DMA_REQ;
				op.idx = 2'($urandom_range(3));
			end else if (r < 55) begin
				op.fn = FN_FRAME_DONE;
				slot = some_owned(planned_table, OWN_DMA);
				if (slot < 0)
					slot = $urandom_range(3);
				op.idx = slot[1:0];
				k = $urandom_range(9);
				if (k < 7)
					op.bytes = planned_table.exp_len;
				else if (k < 9)
					op.bytes = planned_table.exp_len ^ (24'd1 << $urandom_range(23));
				else
					op.bytes = 24'($urandom());
			end else if (r < 72) begin
				op.fn = FN_ACQUIRE;
				op.bytes = 24'($urandom());
			end else if (r < 90) begin
				op.fn = FN_RELEASE;
				slot = some_owned(planned_table, OWN_READING);
				if (slot < 0 || $urandom_range(4) == 0)
					slot = $urandom_range(3);
				op.idx = slot[1:0];
			end else begin
				op.fn = func_t'($urandom_range(3));
				op.idx = 2'($urandom_range(3));
				op.bytes = 24'($urandom());
			end
			queue_op(op);
		end
		wait_drained();
	endtask

	initial begin : stimulus
		logic [BYTES_W-1:0] fb;
		arst_n <= 1'b0;
		tracked_table = table_at_reset();
		planned_table = table_at_reset();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fb = FRAME_BYTES_RST;
		// Empty table, releases of nothing, frames that land on no DMA buffer.
		queue_op(own_op_t'{FN_ACQUIRE, 2'd0, 24'd0});
		queue_op(own_op_t'{FN_RELEASE, NO_BUFFER, 24'd0});
		queue_op(own_op_t'{FN_RELEASE, 2'd0, 24'hFFFFFF});
		queue_op(own_op_t'{FN_FRAME_DONE, NO_BUFFER, fb});
		queue_op(own_op_t'{FN_FRAME_DONE, 2'd1, 24'd0});
		// Fill every buffer, then ask once more with nothing free or ready.
		queue_op(own_op_t'{FN_DMA_REQ, 2'd0, 24'd0});
		queue_op(own_op_t'{FN_DMA_REQ, 2'd1, 24'd0});
		queue_op(own_op_t'{FN_DMA_REQ, 2'd2, 24'd0});
		queue_op(own_op_t'{FN_DMA_REQ, 2'd3, 24'hFFFFFF});
		// A newer good frame frees the older ready one.
		queue_op(own_op_t'{FN_FRAME_DONE, 2'd0, fb});
		queue_op(own_op_t'{FN_FRAME_DONE, 2'd1, fb});
		// The second request finds nothing free and drops the ready frame.
		queue_op(own_op_t'{FN_DMA_REQ, 2'd0, 24'd0});
		queue_op(own_op_t'{FN_DMA_REQ, 2'd0, 24'd0});
		queue_op(own_op_t'{FN_FRAME_DONE, 2'd2, 24'hFFFFFF});
		queue_op(own_op_t'{FN_FRAME_DONE, 2'd0, fb});
		queue_op(own_op_t'{FN_ACQUIRE, 2'd3, 24'd0});
		queue_op(own_op_t'{FN_ACQUIRE, 2'd0, 24'd0});
		queue_op(own_op_t'{FN_FRAME_DONE, 2'd1, fb});
		queue_op(own_op_t'{FN_RELEASE, 2'd2, 24'd0});
		queue_op(own_op_t'{FN_RELEASE, 2'd0, 24'd0});
		queue_op(own_op_t'{FN_DMA_REQ, 2'd0, 24'd0});
		queue_op(own_op_t'{FN_FRAME_DONE, 2'd0, 24'd0});
		queue_op(own_op_t'{FN_ACQUIRE, 2'd0, 24'd0});
		queue_op(own_op_t'{FN_RELEASE, 2'd1, 24'd0});
		wait_drained();

		set_expected_len(24'd0);
		run_phase(130, 0, 0, 1'b1);
		set_expected_len(24'hFFFFFF);
		run_phase(125, 60, 0, 1'b0);
		fb = 24'($urandom());
		set_expected_len(fb);
		run_phase(125, 0, 60, 1'b1);
		set_expected_len(FRAME_BYTES_RST);
		run_phase(125, 33, 33, 1'b0);

		$display("Ran %0d ownership operations under %0d expected frame sizes and four pacing",
			n_ops, n_settings);
		$display("phases; %0d replies compared, %0d grants, %0d mismatches.", n_replies,
			n_grants, n_errors);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tfbo_pkg.sv
hdl/tfbo_ctrl.sv
hdl/tfbo_datapath.sv
hdl/triple_frame_buffer_owner.sv
hdl/tfbo_checker.sv
tb/tb_top.sv
